// ===== sv/vtq_pkg.sv =====
package vtq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_REGS = 8;
  localparam int CFG_IDX_W = 4;
  localparam int NUM_W = 32 + FRAC_BITS;
  localparam int SUM_W = 66;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_WZERO = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic [63:0] ONE_Q = 64'(1) << FRAC_BITS;

  typedef logic signed [31:0] elem_t;
  typedef logic [NUM_REGS-1:0][63:0] mtx_t;

  localparam mtx_t MTX_RESET = {ONE_Q << 32, 64'd0, ONE_Q, 64'd0,
                                64'd0, ONE_Q << 32, 64'd0, ONE_Q};

  typedef struct packed {
    logic             valid;
    logic             point;
    logic [3:0]       sat;
    logic [3:0][31:0] res;
  } colsum_t;

  typedef struct packed {
    logic             valid;
    logic             point;
    logic             wzero;
    logic             sat;
    logic [2:0][31:0] res;
  } dctl_t;

endpackage

// ===== sv/vtq_mac.sv =====
module vtq_mac (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_point,
  input  vtq_pkg::elem_t  in_x,
  input  vtq_pkg::elem_t  in_y,
  input  vtq_pkg::elem_t  in_z,
  input  vtq_pkg::mtx_t   mtx,
  output vtq_pkg::colsum_t cs
);
  import vtq_pkg::*;

  localparam logic signed [SUM_W:0] MAXV = (SUM_W+1)'(64'sd2147483647);
  localparam logic signed [SUM_W:0] MINV = -MAXV - (SUM_W+1)'(1);

  elem_t vin [3];
  elem_t m [4][4];
  logic signed [63:0] prod [4][3];
  logic signed [SUM_W-1:0] sum [4];
  logic signed [SUM_W:0] tot [4];
  logic v1, pt1, v2, pt2;

  always_comb begin
    vin[0] = in_x;
    vin[1] = in_y;
    vin[2] = in_z;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = mtx[r*2 + (c >> 1)][(c & 1)*32 +: 32];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 3; r++) begin
        prod[c][r] <= vin[r] * m[r][c];
      end
      sum[c] <= SUM_W'(prod[c][0]) + SUM_W'(prod[c][1]) + SUM_W'(prod[c][2]);
    end
    pt1 <= in_point;
    pt2 <= pt1;
    cs.point <= pt2;
    for (int c = 0; c < 4; c++) begin
      if (tot[c] > MAXV) begin
        cs.res[c] <= 32'h7fff_ffff;
        cs.sat[c] <= 1'b1;
      end else if (tot[c] < MINV) begin
        cs.res[c] <= 32'h8000_0000;
        cs.sat[c] <= 1'b1;
      end else begin
        cs.res[c] <= tot[c][31:0];
        cs.sat[c] <= 1'b0;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      tot[c] = (SUM_W+1)'(sum[c] >>> FRAC_BITS)
             + (pt2 ? (SUM_W+1)'(m[3][c]) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      cs.valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      cs.valid <= v2;
    end
  end

endmodule

// ===== sv/vtq_div_lane.sv =====
module vtq_div_lane (
  input  logic                      clk,
  input  logic [vtq_pkg::NUM_W-1:0] num,
  input  logic [31:0]               den,
  output logic [vtq_pkg::NUM_W-1:0] quo
);
  import vtq_pkg::*;

  logic [NUM_W-1:0] q [NUM_W];
  logic [31:0] r [NUM_W];
  logic [31:0] d [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] q_in;
    logic [31:0] r_in, d_in, shifted;
    logic [32:0] diff;
    logic ge;

    if (k == 0) begin : g_first
      assign q_in = num;
      assign r_in = '0;
      assign d_in = den;
    end else begin : g_next
      assign q_in = q[k-1];
      assign r_in = r[k-1];
      assign d_in = d[k-1];
    end

    always_comb begin
      shifted = {r_in[30:0], q_in[NUM_W-1]};
      diff = {1'b0, shifted} - {1'b0, d_in};
      ge = !diff[32];
    end

    always_ff @(posedge clk) begin
      r[k] <= ge ? diff[31:0] : shifted;
      q[k] <= {q_in[NUM_W-2:0], ge};
      d[k] <= d_in;
    end
  end

  assign quo = q[NUM_W-1];

endmodule

// ===== sv/vertex_transform_q16.sv =====
// vertex transform, Q16.16 row vector times 4x4 matrix, w divide for points
// input: a transaction is taken at each clock edge with start high and busy
// low; busy stays low, so a vertex may enter in every cycle
// config: cfg_valid/cfg_ready write channel, cfg_index selects the 64-bit
// register (two matrix elements), unknown indexes are dropped; cfg_ready is
// always high; write only while no vertex is in flight
// output: done is high for one cycle with out_x, out_y, out_z and status;
// the receiver cannot stall and the block never holds a result back
// pipeline: from the accepting edge, a vertex passes three multiply/sum/
// saturate stages, one divider set-up stage, one restoring divider stage per
// quotient bit and the output register
// throughput: one vertex per cycle
// reset: clears the pipeline valid bits and loads the identity matrix
module vertex_transform_q16 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action,
  input  logic signed [31:0]            in_x,
  input  logic signed [31:0]            in_y,
  input  logic signed [31:0]            in_z,
  output logic                          done,
  output logic signed [31:0]            out_x,
  output logic signed [31:0]            out_y,
  output logic signed [31:0]            out_z,
  output logic [1:0]                    status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vtq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);
  import vtq_pkg::*;

  localparam int LAT = NUM_W + 5;
  localparam logic [NUM_W-1:0] QMAX = NUM_W'(32'h7fff_ffff);
  localparam logic [NUM_W-1:0] QMIN = NUM_W'(33'h1_0000_0000 >> 1);

  mtx_t mtx;
  colsum_t cs;
  dctl_t prep;
  dctl_t ctl [NUM_W];
  logic [NUM_W-1:0] num_mag [3];
  logic [NUM_W-1:0] quo [3];
  logic [31:0] den_mag;
  logic neg [3];
  logic negd [NUM_W][3];
  logic [31:0] qres [3];
  logic qsat [3];

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mtx <= MTX_RESET;
    end else if (cfg_valid && cfg_ready && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
      mtx[cfg_index[2:0]] <= cfg_data;
    end
  end

  vtq_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .in_point (!action),
    .in_x     (in_x),
    .in_y     (in_y),
    .in_z     (in_z),
    .mtx      (mtx),
    .cs       (cs)
  );

  // divider set-up: magnitudes and quotient signs
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      logic signed [NUM_W-1:0] n;
      n = NUM_W'($signed(cs.res[c])) <<< FRAC_BITS;
      num_mag[c] <= cs.res[c][31] ? NUM_W'(-n) : NUM_W'(n);
      neg[c] <= cs.res[c][31] ^ cs.res[3][31];
    end
    den_mag <= cs.res[3][31] ? 32'(-cs.res[3]) : cs.res[3];
    prep.point <= cs.point;
    prep.wzero <= cs.res[3] == '0;
    prep.sat <= (|cs.sat[2:0]) || (cs.point && cs.sat[3]);
    prep.res <= cs.res[2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep.valid <= 1'b0;
    end else begin
      prep.valid <= cs.valid;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    vtq_div_lane u_div (
      .clk (clk),
      .num (num_mag[c]),
      .den (den_mag),
      .quo (quo[c])
    );
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_W; k++) begin
      if (k == 0) begin
        ctl[k].point <= prep.point;
        ctl[k].wzero <= prep.wzero;
        ctl[k].sat <= prep.sat;
        ctl[k].res <= prep.res;
        negd[k] <= neg;
      end else begin
        ctl[k].point <= ctl[k-1].point;
        ctl[k].wzero <= ctl[k-1].wzero;
        ctl[k].sat <= ctl[k-1].sat;
        ctl[k].res <= ctl[k-1].res;
        negd[k] <= negd[k-1];
      end
    end
    if (rst) begin
      for (int k = 0; k < NUM_W; k++) begin
        ctl[k].valid <= 1'b0;
      end
      done <= 1'b0;
    end else begin
      for (int k = 0; k < NUM_W; k++) begin
        ctl[k].valid <= (k == 0) ? prep.valid : ctl[k-1].valid;
      end
      done <= ctl[NUM_W-1].valid;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (negd[NUM_W-1][c]) begin
        qsat[c] = quo[c] > QMIN;
        qres[c] = qsat[c] ? 32'h8000_0000 : 32'(-quo[c]);
      end else begin
        qsat[c] = quo[c] > QMAX;
        qres[c] = qsat[c] ? 32'h7fff_ffff : quo[c][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ctl[NUM_W-1].point) begin
      out_x <= ctl[NUM_W-1].res[0];
      out_y <= ctl[NUM_W-1].res[1];
      out_z <= ctl[NUM_W-1].res[2];
      status <= ctl[NUM_W-1].sat ? ST_SAT : ST_OK;
    end else if (ctl[NUM_W-1].wzero) begin
      out_x <= '0;
      out_y <= '0;
      out_z <= '0;
      status <= ST_WZERO;
    end else begin
      out_x <= qres[0];
      out_y <= qres[1];
      out_z <= qres[2];
      status <= (ctl[NUM_W-1].sat || qsat[0] || qsat[1] || qsat[2]) ? ST_SAT : ST_OK;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done) else $error("result missing after fixed latency");

  a_wzero: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_WZERO |-> out_x == 0 && out_y == 0 && out_z == 0)
    else $error("zero w result not cleared");

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> status != 2'd3) else $error("undefined status code");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import vtq_pkg::*;

  localparam int LATENCY   = NUM_W + 5;
  localparam int MAX_CYCLE = 2000000;
  localparam int NUM_RAND  = 1800;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [1:0]         st;
  } vtx_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic action = 1'b0;
  logic signed [31:0] in_x = '0, in_y = '0, in_z = '0;
  logic done;
  logic signed [31:0] out_x, out_y, out_z;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [63:0] mtx [NUM_REGS];
  vtx_res_t vtx_queue[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;

  vertex_transform_q16 i_dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("error at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic signed [63:0] elem_of(int r, int c);
    logic [63:0] w;
    w = mtx[r*2 + c/2];
    return (c % 2) ? 64'(signed'(w[63:32])) : 64'(signed'(w[31:0]));
  endfunction

  function automatic logic signed [127:0] col_sum(logic signed [63:0] v[3], int c, bit with_t);
    logic signed [127:0] acc;
    acc = 0;
    for (int r = 0; r < 3; r++)
      acc += 128'(v[r]) * 128'(elem_of(r, c));
    acc = acc >>> FRAC_BITS;
    if (with_t)
      acc += 128'(elem_of(3, c));
    return acc;
  endfunction

  function automatic logic signed [127:0] clamp32(logic signed [127:0] v, ref bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1;
      return 128'sd2147483647;
    end
    if (v < -128'sd2147483648) begin
      sat = 1;
      return -128'sd2147483648;
    end
    return v;
  endfunction

  function automatic vtx_res_t transform(logic act, logic signed [31:0] x,
                                         logic signed [31:0] y, logic signed [31:0] z);
    logic signed [63:0] v[3];
    logic signed [127:0] r[3];
    logic signed [127:0] w;
    bit sat;
    vtx_res_t o;
    sat = 0;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    for (int c = 0; c < 3; c++)
      r[c] = clamp32(col_sum(v, c, !act), sat);
    if (act) begin
      o.st = sat ? ST_SAT : ST_OK;
    end else begin
      w = clamp32(col_sum(v, 3, 1'b1), sat);
      if (w == 0) begin
        for (int c = 0; c < 3; c++)
          r[c] = 0;
        o.st = ST_WZERO;
      end else begin
        for (int c = 0; c < 3; c++)
          r[c] = clamp32((r[c] <<< FRAC_BITS) / w, sat);
        o.st = sat ? ST_SAT : ST_OK;
      end
    end
    o.x = r[0][31:0];
    o.y = r[1][31:0];
    o.z = r[2][31:0];
    return o;
  endfunction

  always @(posedge clk) begin
    vtx_res_t e;
    if (!rst && done) begin
      if (vtx_queue.size() == 0) begin
        report("result with no vertex pending");
      end else begin
        e = vtx_queue.pop_front();
        if (out_x !== e.x) report($sformatf("out_x %h exp %h", out_x, e.x));
        if (out_y !== e.y) report($sformatf("out_y %h exp %h", out_y, e.y));
        if (out_z !== e.z) report($sformatf("out_z %h exp %h", out_z, e.z));
        if (status !== e.st) report($sformatf("status %0d exp %0d", status, e.st));
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_REGS)
      mtx[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (vtx_queue.size() != 0)
      @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic send_vertex(input logic act, input logic signed [31:0] x,
                             input logic signed [31:0] y, input logic signed [31:0] z,
                             input bit known, input vtx_res_t want);
    vtx_res_t p;
    if (!calm)
      while ($urandom_range(99) < 32) begin
        start <= 1'b0;
        @(negedge clk);
      end
    start  <= 1'b1;
    action <= act;
    in_x   <= x;
    in_y   <= y;
    in_z   <= z;
    do @(posedge clk); while (busy);
    p = transform(act, x, y, z);
    if (known && p !== want)
      report("predictor disagrees with table row");
    vtx_queue.push_back(p);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'(signed'($urandom_range(0, 20'hfffff)) - 20'sh80000);
      2: return {$urandom_range(1) ? 16'hffff : 16'h0, 16'($urandom)};
      3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'(signed'($urandom_range(0, 24'h3fffff)) - 24'sh200000);
    endcase
  endfunction

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'(signed'($urandom_range(0, 18'h3ffff)) - 18'sh20000);
      2: return 32'(signed'($urandom_range(0, 22'h3fffff)) - 22'sh200000);
      default: return 32'(signed'($urandom_range(0, 20'hfffff)) - 20'sh80000);
    endcase
  endfunction

  typedef struct {
    logic act;
    logic signed [31:0] x, y, z;
    bit known;
    vtx_res_t want;
  } row_t;

  row_t table_rows[] = '{
    '{1'b0, 32'h00010000, 32'h00020000, 32'h00030000, 1,
      '{32'h00010000, 32'h00020000, 32'h00030000, ST_OK}},
    '{1'b1, 32'h00010000, 32'h00020000, 32'h00030000, 1,
      '{32'h00010000, 32'h00020000, 32'h00030000, ST_OK}},
    '{1'b0, 32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 32'h0, ST_OK}},
    '{1'b1, 32'h7fffffff, 32'h80000000, 32'hffffffff, 1,
      '{32'h7fffffff, 32'h80000000, 32'hffffffff, ST_OK}},
    '{1'b0, 32'h7fffffff, 32'h80000000, 32'h00000001, 0, '{0, 0, 0, 0}},
    '{1'b0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, '{0, 0, 0, 0}}
  };

  initial begin
    logic [63:0] vals[4];
    foreach (mtx[i]) mtx[i] = MTX_RESET[i];
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (table_rows[i])
      send_vertex(table_rows[i].act, table_rows[i].x, table_rows[i].y, table_rows[i].z,
                  table_rows[i].known, table_rows[i].want);
    drain();

    // w column zero: every point gives the w-zero status
    write_reg(4'd1, 64'h0);
    write_reg(4'd3, 64'h0);
    write_reg(4'd5, 64'h00010000);
    write_reg(4'd7, 64'h0);
    send_vertex(1'b0, 32'h00050000, 32'h7fffffff, 32'h80000000, 1, '{0, 0, 0, ST_WZERO});
    send_vertex(1'b1, 32'h00050000, 32'h0, 32'h0, 1, '{32'h00050000, 0, 0, ST_OK});
    drain();

    // extremes: even regs most negative, odd regs most positive, plus an unknown index
    foreach (vals[i]) vals[i] = (i % 2) ? 64'h7fffffff7fffffff : 64'h8000000080000000;
    for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_IDX_W'(i), vals[i % 2]);
    write_reg(4'd12, 64'hdeadbeefdeadbeef);
    send_vertex(1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, '{0, 0, 0, 0});
    send_vertex(1'b1, 32'h80000000, 32'h80000000, 32'h80000000, 0, '{0, 0, 0, 0});
    send_vertex(1'b0, 32'h00000001, 32'hffffffff, 32'h00010000, 0, '{0, 0, 0, 0});
    send_vertex(1'b0, 32'h80000000, 32'h0, 32'h0, 0, '{0, 0, 0, 0});
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (ph == 0)
          write_reg(CFG_IDX_W'(i), MTX_RESET[i]);
        else
          write_reg(CFG_IDX_W'(i), {rand_elem(), rand_elem()});
      end
      if (ph == 5) begin
        write_reg(4'd1, {32'h0, rand_elem()});
        write_reg(4'd3, {32'h0, rand_elem()});
        write_reg(4'd5, {32'h0, rand_elem()});
        write_reg(4'd7, 64'h0);
      end
      calm = (ph == 2);
      for (int n = 0; n < NUM_RAND / 6; n++)
        send_vertex($urandom_range(1), rand_coord(), rand_coord(), rand_coord(),
                    0, '{0, 0, 0, 0});
      drain();
    end

    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
